FILE: src/mmre_pkg.sv
// shared constants and types for the matrix multiply row engine
`timescale 1ns / 1ps

package mmre_pkg;

  localparam int DIM_DEFAULT = 16;
  localparam int VALUE_W     = 16;
  localparam int PROD_W      = 2 * VALUE_W;
  localparam int ACC_W       = 38;
  localparam int IDX_W       = 6;

  localparam logic MODE_STORE_B = 1'b0;
  localparam logic MODE_A_ELEM  = 1'b1;

  // control word that travels with one multiply-accumulate step
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] col;
    logic             last;
  } lane_ctl_t;

endpackage

FILE: src/mmre_accum.sv
// accumulator memory with multiply, read-modify-write and result register
`timescale 1ns / 1ps

module mmre_accum #(
  parameter int DIM = mmre_pkg::DIM_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mmre_pkg::lane_ctl_t                 issue,
  input  logic signed [mmre_pkg::VALUE_W-1:0] a_val,
  input  logic signed [mmre_pkg::VALUE_W-1:0] b_val,
  output logic                                pipe_busy,
  output logic                                result_strobe,
  output logic signed [mmre_pkg::ACC_W-1:0]   product_value,
  output logic [mmre_pkg::IDX_W-1:0]          out_column,
  output logic                                row_done
);

  localparam int CW = $clog2(DIM);

  logic signed [mmre_pkg::ACC_W-1:0]  acc_mem [DIM];
  logic [DIM-1:0]                     acc_vld;

  logic signed [mmre_pkg::ACC_W-1:0]  acc_q;
  logic                               vld_q;
  logic signed [mmre_pkg::ACC_W-1:0]  acc2;
  logic signed [mmre_pkg::PROD_W-1:0] prod_q;
  mmre_pkg::lane_ctl_t                s1;
  mmre_pkg::lane_ctl_t                s2;
  logic signed [mmre_pkg::ACC_W-1:0]  sum;
  logic [CW-1:0]                      rd_idx;
  logic [CW-1:0]                      wr_idx;

  assign rd_idx    = issue.col[CW-1:0];
  assign wr_idx    = s2.col[CW-1:0];
  assign sum       = acc2 + mmre_pkg::ACC_W'(prod_q);
  assign pipe_busy = s1.valid | s2.valid;

  // accumulator memory, registered read
  always_ff @(posedge clk) begin
    acc_q <= acc_mem[rd_idx];
    vld_q <= acc_vld[rd_idx];
    if (s2.valid && !s2.last) begin
      acc_mem[wr_idx] <= sum;
    end
  end

  // entries not valid read as zero; the last k of a row clears them
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld <= '0;
    end else if (s2.valid) begin
      acc_vld[wr_idx] <= !s2.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_q <= a_val * b_val;
    acc2   <= vld_q ? acc_q : '0;
    product_value <= sum;
    out_column    <= s2.col;
    row_done      <= s2.valid && s2.last && (wr_idx == CW'(DIM - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1            <= '0;
      s2            <= '0;
      result_strobe <= 1'b0;
    end else begin
      s1            <= issue;
      s2            <= s1;
      result_strobe <= s2.valid && s2.last;
    end
  end

`ifndef SYNTHESIS
  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (rst)
    (s2.valid && issue.valid) |-> (s2.col != issue.col))
    else $error("accumulator read overlaps pending write");

  a_done_has_strobe: assert property (@(posedge clk) disable iff (rst)
    row_done |-> result_strobe)
    else $error("row_done without result strobe");

  a_row_contiguous: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !row_done) |=> result_strobe)
    else $error("gap inside an emitted row");
`endif

endmodule

FILE: src/matrix_multiply_row_engine.sv
// top level of the matrix multiply row engine: b store and step sequencer
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// command   in         start & !busy          mode, row_index, col_index, value
// result    out        result_strobe (1 cyc)  product_value, out_column, row_done
//
// a b element is written in the cycle it is accepted; busy stays low
// an in-range a element holds busy for DIM issue steps through the b store
// read port plus the multiply and accumulate stages behind it, so no new command
// is taken until its last step has left the accumulate stage
// the last a element of a row emits DIM results on consecutive cycles
// reset clears the sequencer and the accumulator valid bits at once
// the receiver cannot stall; each result transaction lasts exactly one cycle
module matrix_multiply_row_engine #(
  parameter int DIM = mmre_pkg::DIM_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode,
  input  logic [mmre_pkg::IDX_W-1:0]          row_index,
  input  logic [mmre_pkg::IDX_W-1:0]          col_index,
  input  logic signed [mmre_pkg::VALUE_W-1:0] value,
  output logic                                result_strobe,
  output logic signed [mmre_pkg::ACC_W-1:0]   product_value,
  output logic [mmre_pkg::IDX_W-1:0]          out_column,
  output logic                                row_done
);

  localparam int CW = $clog2(DIM);
  localparam int AW = $clog2(DIM * DIM);

  typedef enum logic {ST_IDLE, ST_ISSUE} state_t;

  state_t                              state;
  logic [CW-1:0]                       cnt;
  logic [CW-1:0]                       k_reg;
  logic                                last_reg;
  logic signed [mmre_pkg::VALUE_W-1:0] a_reg;

  // b store, row-major, no reset: the user must write every entry before it is read; not enforced
  logic signed [mmre_pkg::VALUE_W-1:0] b_mem [DIM * DIM];
  logic signed [mmre_pkg::VALUE_W-1:0] b_q;

  logic                accept;
  logic                row_ok;
  logic                col_ok;
  logic [AW-1:0]       b_wr_addr;
  logic [AW-1:0]       b_rd_addr;
  logic                pipe_busy;
  mmre_pkg::lane_ctl_t issue;

  assign accept = start && !busy;
  assign row_ok = {1'b0, row_index} < (mmre_pkg::IDX_W + 1)'(DIM);
  assign col_ok = {1'b0, col_index} < (mmre_pkg::IDX_W + 1)'(DIM);
  assign busy   = (state != ST_IDLE) || pipe_busy;

  // index math: row * DIM + col, constant multiply
  assign b_wr_addr = AW'(row_index) * AW'(DIM) + AW'(col_index);
  assign b_rd_addr = AW'(k_reg) * AW'(DIM) + AW'(cnt);

  // one step per cycle: b[k][j] and acc[j] are read together
  assign issue.valid = (state == ST_ISSUE);
  assign issue.col   = mmre_pkg::IDX_W'(cnt);
  assign issue.last  = last_reg;

  always_ff @(posedge clk) begin
    if (accept && (mode == mmre_pkg::MODE_STORE_B) && row_ok && col_ok) begin
      b_mem[b_wr_addr] <= value;
    end
    b_q <= b_mem[b_rd_addr];
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      k_reg    <= '0;
      last_reg <= 1'b0;
      a_reg    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && (mode == mmre_pkg::MODE_A_ELEM) && col_ok) begin
            a_reg    <= value;
            k_reg    <= col_index[CW-1:0];
            last_reg <= (col_index == mmre_pkg::IDX_W'(DIM - 1));
            cnt      <= '0;
            state    <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(DIM - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a_reg holds for the whole item, so it lines up with b_q at stage one
  mmre_accum #(
    .DIM(DIM)
  ) u_accum (
    .clk           (clk),
    .rst           (rst),
    .issue         (issue),
    .a_val         (a_reg),
    .b_val         (b_q),
    .pipe_busy     (pipe_busy),
    .result_strobe (result_strobe),
    .product_value (product_value),
    .out_column    (out_column),
    .row_done      (row_done)
  );

endmodule

FILE: dv/tb_matrix_multiply_row_engine.sv
// self-checking testbench for the matrix multiply row engine
`timescale 1ns / 1ps

module tb_matrix_multiply_row_engine;

  localparam int DIM          = mmre_pkg::DIM_DEFAULT;
  localparam int RANDOM_ITEMS = 40;    // counted in-range transactions in the random part
  localparam int QUIET_FROM   = 200;   // accepted transactions with no sender gaps
  localparam int QUIET_TO     = 300;

  // one command transaction as driven on the ports
  typedef struct {
    logic                                mode;
    logic [mmre_pkg::IDX_W-1:0]          row;
    logic [mmre_pkg::IDX_W-1:0]          col;
    logic signed [mmre_pkg::VALUE_W-1:0] value;
  } matrix_cmd_t;

  // one element of an emitted product row
  typedef struct {
    logic [mmre_pkg::ACC_W-1:0] sum;
    logic [mmre_pkg::IDX_W-1:0] col;
    logic                       last;
  } row_element_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic                                busy;
  logic                                mode = mmre_pkg::MODE_STORE_B;
  logic [mmre_pkg::IDX_W-1:0]          row_index = '0;
  logic [mmre_pkg::IDX_W-1:0]          col_index = '0;
  logic signed [mmre_pkg::VALUE_W-1:0] value = '0;
  logic                                result_strobe;
  logic signed [mmre_pkg::ACC_W-1:0]   product_value;
  logic [mmre_pkg::IDX_W-1:0]          out_column;
  logic                                row_done;

  matrix_cmd_t  pending_cmds[$];
  row_element_t expected_row_elems[$];

  // shadow copy of the block state
  logic signed [mmre_pkg::VALUE_W-1:0] b_shadow [DIM*DIM];
  logic [mmre_pkg::ACC_W-1:0]          acc_shadow [DIM];

  int  error_count    = 0;
  int  accepted_count = 0;
  int  elems_checked  = 0;
  int  rows_checked   = 0;
  bit  cmd_taken;
  row_element_t elem_want;

  matrix_multiply_row_engine #(
    .DIM(DIM)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .row_index    (row_index),
    .col_index    (col_index),
    .value        (value),
    .result_strobe(result_strobe),
    .product_value(product_value),
    .out_column   (out_column),
    .row_done     (row_done)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // shadow model: b writes land in the store, a elements multiply a
  // whole stored row of b into the accumulators; k = DIM-1 emits the row
  // ------------------------------------------------------------------
  task automatic update_product_model(input matrix_cmd_t c);
    logic signed [mmre_pkg::PROD_W-1:0] prod;
    row_element_t                       e;
    int                                 j;
    if (c.mode == mmre_pkg::MODE_STORE_B) begin
      // out-of-range b writes are dropped
      if (c.row < DIM && c.col < DIM) b_shadow[c.row*DIM + c.col] = c.value;
    end else if (c.col < DIM) begin
      for (j = 0; j < DIM; j++) begin
        prod = c.value * b_shadow[c.col*DIM + j];
        // exact sum, wraps modulo 2^38 only when k repeats many times
        acc_shadow[j] = acc_shadow[j] +
                        {{(mmre_pkg::ACC_W-mmre_pkg::PROD_W){prod[mmre_pkg::PROD_W-1]}}, prod};
      end
      // last inner index closes the row, whatever came before it
      if (c.col == DIM-1) begin
        for (j = 0; j < DIM; j++) begin
          e.sum  = acc_shadow[j];
          e.col  = j[mmre_pkg::IDX_W-1:0];
          e.last = (j == DIM-1);
          expected_row_elems.push_back(e);
          acc_shadow[j] = '0;
        end
      end
    end
  endtask

  // ------------------------------------------------------------------
  // stimulus builders
  // ------------------------------------------------------------------
  function automatic logic signed [mmre_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return mmre_pkg::VALUE_W'($urandom);
    endcase
  endfunction

  task automatic push_b(input int r, input int c,
                        input logic signed [mmre_pkg::VALUE_W-1:0] v);
    matrix_cmd_t cmd;
    cmd.mode  = mmre_pkg::MODE_STORE_B;
    cmd.row   = r[mmre_pkg::IDX_W-1:0];
    cmd.col   = c[mmre_pkg::IDX_W-1:0];
    cmd.value = v;
    pending_cmds.push_back(cmd);
  endtask

  // row_index is a don't-care for a elements, so it gets random bits
  task automatic push_a(input int k, input logic signed [mmre_pkg::VALUE_W-1:0] v);
    matrix_cmd_t cmd;
    cmd.mode  = mmre_pkg::MODE_A_ELEM;
    cmd.row   = mmre_pkg::IDX_W'($urandom_range(0, 63));
    cmd.col   = k[mmre_pkg::IDX_W-1:0];
    cmd.value = v;
    pending_cmds.push_back(cmd);
  endtask

  // ------------------------------------------------------------------
  // driver: a transaction is taken at an edge with start high and busy
  // low; start holds while busy, drops on random gaps or an empty queue
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      cmd_taken = start && !busy;
      if (cmd_taken) begin
        update_product_model(pending_cmds.pop_front());
        accepted_count++;
      end
      if (cmd_taken || !start) begin
        if (pending_cmds.size() != 0 &&
            ((accepted_count >= QUIET_FROM && accepted_count < QUIET_TO) ||
             $urandom_range(0, 99) >= 25)) begin
          start     <= 1'b1;
          mode      <= pending_cmds[0].mode;
          row_index <= pending_cmds[0].row;
          col_index <= pending_cmds[0].col;
          value     <= pending_cmds[0].value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // monitor: each strobed result is matched against the oldest
  // expected row element; the receiver never stalls
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (expected_row_elems.size() == 0) begin
        $display("%0t: unexpected result col %0d value %0d done %0b",
                 $time, out_column, product_value, row_done);
        error_count++;
      end else begin
        elem_want = expected_row_elems.pop_front();
        elems_checked++;
        if (row_done) rows_checked++;
        if (product_value !== elem_want.sum) begin
          $display("%0t: product_value col %0d expected %0d actual %0d",
                   $time, elem_want.col, $signed(elem_want.sum), product_value);
          error_count++;
        end
        if (out_column !== elem_want.col) begin
          $display("%0t: out_column expected %0d actual %0d",
                   $time, elem_want.col, out_column);
          error_count++;
        end
        if (row_done !== elem_want.last) begin
          $display("%0t: row_done col %0d expected %0b actual %0b",
                   $time, elem_want.col, elem_want.last, row_done);
          error_count++;
        end
      end
    end
  end

  // watchdog, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // stimulus and end of run
  // ------------------------------------------------------------------
  initial begin
    int load_order [DIM*DIM];
    int i, k, n, tmp, pick, counted;
    foreach (b_shadow[i]) b_shadow[i] = '0;
    foreach (acc_shadow[i]) acc_shadow[i] = '0;

    // load every b entry once, in shuffled order, so no a element ever
    // reads an unwritten entry
    for (i = 0; i < DIM*DIM; i++) load_order[i] = i;
    for (i = DIM*DIM-1; i > 0; i--) begin
      pick             = $urandom_range(0, i);
      tmp              = load_order[i];
      load_order[i]    = load_order[pick];
      load_order[pick] = tmp;
    end
    for (i = 0; i < DIM*DIM; i++) push_b(load_order[i] / DIM, load_order[i] % DIM, pick_value());

    // directed: index extremes and out-of-range b writes
    push_b(63, 63, 16'h7fff);
    push_b(DIM, 0, 16'h1234);
    push_b(0, DIM, 16'h4321);
    push_b(0, 0, 16'h7fff);
    push_b(DIM-1, DIM-1, 16'h8000);
    push_b(DIM-1, 0, 16'h8000);
    // out-of-range a elements leave the accumulators alone
    push_a(DIM, 16'h7fff);
    push_a(63, 16'h8000);
    // row with only the closing element, full negative scale
    push_a(DIM-1, 16'h8000);
    // row with the middle missing
    push_a(0, 16'h7fff);
    push_a(DIM-1, 16'h8000);
    // repeated inner index
    push_a(0, 16'h8000);
    push_a(0, 16'hffff);
    push_a(DIM-1, 16'h0001);
    // full in-order row of zeros
    for (k = 0; k < DIM; k++) push_a(k, 16'h0000);

    // random part, mostly well-formed rows with random content
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        for (k = 0; k < DIM; k++) push_a(k, pick_value());
        counted += DIM;
      end else if (pick < 58) begin
        // rewrite a few b entries
        n = $urandom_range(1, 8);
        repeat (n) push_b($urandom_range(0, DIM-1), $urandom_range(0, DIM-1), pick_value());
        counted += n;
      end else if (pick < 70) begin
        // broken row: missing, repeated and shuffled k before the close
        n = $urandom_range(0, 20);
        repeat (n) push_a($urandom_range(0, DIM-2), pick_value());
        push_a(DIM-1, pick_value());
        counted += n + 1;
      end else if (pick < 80) begin
        // noise the block ignores
        case ($urandom_range(0, 2))
          0:       push_b($urandom_range(DIM, 63), $urandom_range(0, 63), pick_value());
          1:       push_b($urandom_range(0, 63), $urandom_range(DIM, 63), pick_value());
          default: push_a($urandom_range(DIM, 63), pick_value());
        endcase
      end else if (pick < 90) begin
        // in-order row with b rewrites slipped between elements
        for (k = 0; k < DIM; k++) begin
          push_a(k, pick_value());
          counted++;
          if ($urandom_range(0, 2) == 0) begin
            push_b($urandom_range(0, DIM-1), $urandom_range(0, DIM-1), pick_value());
            counted++;
          end
        end
      end else begin
        push_a($urandom_range(0, DIM-1), pick_value());
        counted++;
      end
    end

    // single reset pulse
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // drain: every command taken and every row element seen
    while (pending_cmds.size() != 0 || start || expected_row_elems.size() != 0)
      @(negedge clk);
    // an a element that closes no row may still be in flight
    repeat (2*DIM + 8) @(posedge clk);

    $display("covered %0d command transactions, %0d result elements in %0d rows",
             accepted_count, elems_checked, rows_checked);
    $display("including full b load, out-of-range indexes, broken and repeated-k rows");
    if (error_count == 0 && expected_row_elems.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/mmre_pkg.sv
src/mmre_accum.sv
src/matrix_multiply_row_engine.sv
dv/tb_matrix_multiply_row_engine.sv
